// ===== rtl/wavelength_to_rgb_color_assert.svh =====
// Assertion macros used by the wavelength_to_rgb_color checker.
`ifndef WAVELENGTH_TO_RGB_COLOR_ASSERT_SVH
`define WAVELENGTH_TO_RGB_COLOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define W2RGB_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("w2rgb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define W2RGB_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("w2rgb assertion failed");

`endif

// ===== rtl/w2rgb_pkg.sv =====
// Types and constants for the wavelength to RGB color converter.
`default_nettype none

package w2rgb_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int WL_BITS      = 10;
	localparam int D_BITS       = 9;
	localparam int R_BITS       = 7;
	localparam int RECIP_BITS   = 30;
	localparam int RECIP_SHIFT  = 36;

	localparam logic [WL_BITS-1:0] W_MIN = WL_BITS'(380);
	localparam logic [WL_BITS-1:0] W_MAX = WL_BITS'(750);
	localparam logic [R_BITS-1:0]  SPAN  = R_BITS'(74);

	// ceil(2^RECIP_SHIFT / SPAN): exact floor(p / SPAN) for every chroma * fraction product
	localparam logic [RECIP_BITS-1:0] SPAN_RECIP =
		RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd73) / 64'd74);

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	typedef struct packed {
		logic [WL_BITS-1:0]      wavelength_nm;
		logic [CHANNEL_BITS-1:0] saturation;
		logic [CHANNEL_BITS-1:0] brightness;
	} light_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
	} rgb_t;

endpackage

`default_nettype wire

// ===== rtl/wavelength_to_rgb_color.sv =====
// Wavelength to RGB color converter: five-stage pipeline top level.
//
// Input channel light (light_valid / light_ready) carries a wavelength in nm,
// a saturation and a brightness. Output channel color (color_valid /
// color_ready) carries the 8-bit red, green and blue result, one per item.
// The wavelength is clamped to 380..750 nm and mapped to a hue sector and a
// fraction of 1/74 steps; HSV is then converted to RGB.
//
// color_valid is the valid bit of the output register, the last of the stage
// registers s1 to s5 through which an accepted input transaction passes.
// Throughput is one item per cycle while color_ready is high: each of the five
// register stages advances whenever the stage after it does, and holds at most
// one multiplier (brightness * saturation, chroma * fraction, reciprocal
// multiply for the divide by 74).
// Reset clears all stage valid bits; light_ready is high out of reset.
// When color_ready is low the result holds in the output register and the
// stages behind it keep filling until each holds an item; then light_ready
// drops. Nothing is lost or repeated across a stall.
`default_nettype none

module wavelength_to_rgb_color
	import w2rgb_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   light_valid,
	output logic        light_ready,
	input  wire light_t light,
	output logic        color_valid,
	input  wire logic   color_ready,
	output rgb_t        color
);

	localparam int N = CHANNEL_BITS;
	localparam int P_BITS = N + R_BITS;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !v_s5 || color_ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign light_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= light_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: clamp, distance from the red end, brightness * saturation
	logic [WL_BITS-1:0] wl_clamp;
	logic [D_BITS-1:0]  d_s1;
	logic [2*N-1:0]     vs_s1;
	logic [N-1:0]       val_s1;

	always_comb begin
		if (light.wavelength_nm < W_MIN)
			wl_clamp = W_MIN;
		else if (light.wavelength_nm > W_MAX)
			wl_clamp = W_MAX;
		else
			wl_clamp = light.wavelength_nm;
	end

	always_ff @(posedge clk) begin
		if (rdy1 && light_valid) begin
			d_s1   <= D_BITS'(W_MAX - wl_clamp);
			vs_s1  <= (2*N)'(light.brightness) * (2*N)'(light.saturation);
			val_s1 <= light.brightness;
		end
	end

	// stage 2: sector and remainder of d / 74, chroma = vs / (2^N - 1)
	logic [2:0]         sec_num;
	logic [D_BITS-1:0]  sec_base;
	logic [2*N:0]       chroma_sum;
	sector_t            sec_s2;
	logic [R_BITS-1:0]  r_s2;
	logic [N-1:0]       chroma_s2;
	logic [N-1:0]       val_s2;

	always_comb begin
		sec_num  = 3'd0;
		sec_base = '0;
		for (int k = 1; k <= 5; k++) begin
			if (d_s1 >= D_BITS'(k * 74)) begin
				sec_num  = 3'(k);
				sec_base = D_BITS'(k * 74);
			end
		end
		// exact floor(x / (2^N - 1)) for any product of two N-bit values
		chroma_sum = (2*N+1)'(vs_s1) + (2*N+1)'(vs_s1 >> N) + (2*N+1)'(1);
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			sec_s2    <= sector_t'(sec_num);
			r_s2      <= R_BITS'(d_s1 - sec_base);
			chroma_s2 <= N'(chroma_sum >> N);
			val_s2    <= val_s1;
		end
	end

	// stage 3: fraction, chroma * fraction, m = V - chroma
	logic [R_BITS-1:0] frac;
	sector_t           sec_s3;
	logic [P_BITS-1:0] p_s3;
	logic [N-1:0]      m_s3;
	logic [N-1:0]      val_s3;

	assign frac = sec_s2[0] ? (SPAN - r_s2) : r_s2;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			sec_s3 <= sec_s2;
			p_s3   <= P_BITS'(chroma_s2) * P_BITS'(frac);
			m_s3   <= val_s2 - chroma_s2;
			val_s3 <= val_s2;
		end
	end

	// stage 4: x = p / 74 through the reciprocal multiply
	logic [P_BITS+RECIP_BITS-1:0] x_prod;
	sector_t      sec_s4;
	logic [N-1:0] x_s4;
	logic [N-1:0] m_s4;
	logic [N-1:0] val_s4;

	assign x_prod = (P_BITS+RECIP_BITS)'(p_s3) * (P_BITS+RECIP_BITS)'(SPAN_RECIP);

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			sec_s4 <= sec_s3;
			x_s4   <= N'(x_prod >> RECIP_SHIFT);
			m_s4   <= m_s3;
			val_s4 <= val_s3;
		end
	end

	// stage 5: place V, x + m and m by sector into the output register
	logic [N-1:0] xm;
	rgb_t         rgb_next;

	assign xm = x_s4 + m_s4;

	always_comb begin
		unique case (sec_s4)
			SEC_RED_YEL: rgb_next = '{red: val_s4, green: xm,     blue: m_s4};
			SEC_YEL_GRN: rgb_next = '{red: xm,     green: val_s4, blue: m_s4};
			SEC_GRN_CYN: rgb_next = '{red: m_s4,   green: val_s4, blue: xm};
			SEC_CYN_BLU: rgb_next = '{red: m_s4,   green: xm,     blue: val_s4};
			SEC_BLU_MAG: rgb_next = '{red: xm,     green: m_s4,   blue: val_s4};
			default:     rgb_next = '{red: val_s4, green: m_s4,   blue: xm};
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			color <= rgb_next;
		end
	end

	assign color_valid = v_s5;

endmodule

`default_nettype wire

// ===== rtl/w2rgb_checker.sv =====
// Port-level checker for wavelength_to_rgb_color and its bind.
`default_nettype none

`include "wavelength_to_rgb_color_assert.svh"

module w2rgb_checker
	import w2rgb_pkg::*;
(
	input wire logic   clk,
	input wire logic   arst_n,
	input wire logic   light_valid,
	input wire logic   light_ready,
	input wire light_t light,
	input wire logic   color_valid,
	input wire logic   color_ready,
	input wire rgb_t   color
);

	logic [CHANNEL_BITS-1:0] color_peak;

	assign color_peak = color.red | color.green | color.blue;

	// hold an unaccepted light transaction with its payload
	`W2RGB_ASSERT_NEXT(a_light_hold, clk, arst_n, light_valid && !light_ready, light_valid && $stable(light))

	// hold an unaccepted result transaction
	`W2RGB_ASSERT_NEXT(a_color_hold, clk, arst_n, color_valid && !color_ready, color_valid)

	// an empty output register means every stage behind it can advance
	`W2RGB_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !color_valid, light_ready)

	// a drained output frees the whole pipeline in the same cycle
	`W2RGB_ASSERT_NOW(a_ready_when_drained, clk, arst_n, color_ready, light_ready)

	// a stalled result keeps the bitwise OR of its three channels
	`W2RGB_ASSERT_NEXT(a_color_peak_stable, clk, arst_n, color_valid && !color_ready, $stable(color_peak))

endmodule

bind wavelength_to_rgb_color w2rgb_checker u_w2rgb_checker (.*);

`default_nettype wire

// ===== tb/wavelength_to_rgb_color_test.sv =====
// Self-checking testbench for the wavelength to RGB color converter.
`timescale 1ns / 100ps
`default_nettype none

module wavelength_to_rgb_color_test;
	import w2rgb_pkg::*;

	localparam int CHAN_MAX     = (1 << CHANNEL_BITS) - 1;
	localparam int RANDOM_ITEMS = 1150;
	localparam int BATCHES      = 5;
	localparam int MAX_WAIT     = 16;

	logic   clk         = 1'b0;
	logic   arst_n      = 1'b0;
	logic   light_valid = 1'b0;
	logic   light_ready;
	light_t light       = '0;
	logic   color_valid;
	logic   color_ready = 1'b0;
	rgb_t   color;

	light_t light_pending[$];
	rgb_t   rgb_expected[$];
	bit     light_taken  = 1'b0;
	bit     color_taken  = 1'b0;
	bit     steady_flow  = 1'b0;
	int     light_gap    = 0;
	int     color_stall  = 0;
	int     error_count  = 0;

	wavelength_to_rgb_color i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.light_valid (light_valid),
		.light_ready (light_ready),
		.light       (light),
		.color_valid (color_valid),
		.color_ready (color_ready),
		.color       (color)
	);

	always #5 clk = ~clk;

	// HSV to RGB with hue taken from the clamped wavelength
	function automatic rgb_t light_to_rgb(light_t l);
		int w, d, r, s, v, chroma, m, x;
		sector_t sec;
		rgb_t c;
		w = int'(l.wavelength_nm);
		s = int'(l.saturation);
		v = int'(l.brightness);
		if (w < int'(W_MIN))
			w = int'(W_MIN);
		if (w > int'(W_MAX))
			w = int'(W_MAX);
		d = int'(W_MAX) - w;
		sec = sector_t'(d / int'(SPAN));
		r = d % int'(SPAN);
		chroma = (v * s) / CHAN_MAX;
		m = v - chroma;
		if (d / int'(SPAN) % 2 == 1)
			x = (chroma * (int'(SPAN) - r)) / int'(SPAN);
		else
			x = (chroma * r) / int'(SPAN);
		case (sec)
			SEC_RED_YEL: c = '{red: v[7:0], green: 8'(x + m), blue: m[7:0]};
			SEC_YEL_GRN: c = '{red: 8'(x + m), green: v[7:0], blue: m[7:0]};
			SEC_GRN_CYN: c = '{red: m[7:0], green: v[7:0], blue: 8'(x + m)};
			SEC_CYN_BLU: c = '{red: m[7:0], green: 8'(x + m), blue: v[7:0]};
			SEC_BLU_MAG: c = '{red: 8'(x + m), green: m[7:0], blue: v[7:0]};
			default:     c = '{red: v[7:0], green: m[7:0], blue: 8'(x + m)};
		endcase
		return c;
	endfunction

	function automatic int draw_wait();
		return steady_flow ? 0 : int'($urandom_range(0, MAX_WAIT));
	endfunction

	function automatic logic [7:0] random_channel();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 8'd0;
		if (pick == 1)
			return 8'(CHAN_MAX);
		return 8'($urandom_range(0, CHAN_MAX));
	endfunction

	// mostly visible light, with some clamped and some arbitrary codes
	function automatic light_t random_light();
		light_t l;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			l.wavelength_nm = WL_BITS'($urandom_range(int'(W_MIN), int'(W_MAX)));
		else if (pick == 7)
			l.wavelength_nm = WL_BITS'($urandom_range(0, int'(W_MIN) - 1));
		else if (pick == 8)
			l.wavelength_nm = WL_BITS'($urandom_range(int'(W_MAX) + 1, (1 << WL_BITS) - 1));
		else
			l.wavelength_nm = WL_BITS'($urandom);
		l.saturation = random_channel();
		l.brightness = random_channel();
		return l;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic queue_light(int w, int s, int v);
		light_t l;
		l.wavelength_nm = WL_BITS'(w);
		l.saturation = CHANNEL_BITS'(s);
		l.brightness = CHANNEL_BITS'(v);
		light_pending = {light_pending, l};
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (light_pending.size() != 0 || light_valid || rgb_expected.size() != 0);
	endtask

	// sender: a new transaction only once the previous one has gone through
	always @(negedge clk) begin
		if (arst_n && (!light_valid || light_taken)) begin
			if (light_gap > 0) begin
				light_gap = light_gap - 1;
				light_valid <= 1'b0;
			end else if (light_pending.size() != 0) begin
				light <= light_pending.pop_front();
				light_valid <= 1'b1;
				light_gap = draw_wait();
			end else
				light_valid <= 1'b0;
		end
	end

	// receiver: draw a new stall after each accepted result
	always @(negedge clk) begin
		if (arst_n) begin
			if (color_taken)
				color_stall = draw_wait();
			if (color_stall > 0) begin
				color_stall = color_stall - 1;
				color_ready <= 1'b0;
			end else
				color_ready <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		rgb_t want;
		if (!arst_n) begin
			light_taken <= 1'b0;
			color_taken <= 1'b0;
		end else begin
			light_taken <= light_valid && light_ready;
			color_taken <= color_valid && color_ready;
			if (light_valid && light_ready)
				rgb_expected = {rgb_expected, light_to_rgb(light)};
			if (color_valid && color_ready) begin
				if (rgb_expected.size() == 0)
					report_mismatch("unexpected result, red", int'(color.red), -1);
				else begin
					want = rgb_expected.pop_front();
					if (color.red != want.red)
						report_mismatch("red", int'(color.red), int'(want.red));
					if (color.green != want.green)
						report_mismatch("green", int'(color.green), int'(want.green));
					if (color.blue != want.blue)
						report_mismatch("blue", int'(color.blue), int'(want.blue));
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// clamping, sector edges and channel extremes
		queue_light(0, 255, 255);
		queue_light(379, 255, 255);
		queue_light(380, 255, 255);
		queue_light(381, 200, 180);
		queue_light(750, 255, 255);
		queue_light(751, 255, 255);
		queue_light(1023, 255, 255);
		queue_light(676, 255, 255);
		queue_light(677, 255, 255);
		queue_light(602, 128, 255);
		queue_light(603, 255, 128);
		queue_light(528, 255, 255);
		queue_light(529, 77, 201);
		queue_light(454, 255, 255);
		queue_light(455, 160, 90);
		queue_light(713, 255, 255);
		queue_light(640, 255, 255);
		queue_light(565, 255, 255);
		queue_light(491, 255, 255);
		queue_light(417, 255, 255);
		queue_light(500, 0, 255);
		queue_light(500, 255, 0);
		queue_light(600, 0, 0);
		queue_light(1023, 0, 0);
		// queue nothing more until the pipeline has emptied
		wait_drained();

		for (int b = 0; b < BATCHES; b++) begin
			steady_flow = (b == 2);
			for (int i = 0; i < RANDOM_ITEMS / BATCHES; i++)
				light_pending = {light_pending, random_light()};
			if (b == 1)
				wait_drained();
		end
		wait_drained();
		steady_flow = 1'b0;
		repeat (20) @(posedge clk);

		if (error_count == 0 && rgb_expected.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
